// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level core RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPTF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define SPTF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SPTF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SPTF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/sptf_pkg.sv =====
// Shared types and codes for the scan turn feature block
`timescale 1ns / 1ps
package sptf_pkg;

  localparam logic OP_SQRT = 1'b0;
  localparam logic OP_DIV  = 1'b1;

  localparam logic [1:0] CFG_ANGLE_START = 2'd0;
  localparam logic [1:0] CFG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] CFG_SCAN_LENGTH = 2'd2;

  typedef struct packed {
    logic        start;
    logic        op;
    logic [63:0] radicand;
    logic [48:0] num;
    logic [32:0] den;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
    logic [17:0] quot;
  } iter_rsp_t;

endpackage

// ===== rtl/scan_polar_turn_features_core.sv =====
// Top level: polar scan samples to turn cross and dot features
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | range_mm
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  out     | out_valid/out_ready  | triple_start_angle, turn_cross, turn_dot,
//          |                      | degenerate, last_of_scan
//
// A new sample is accepted only once the sequencer is back in idle. The time of a full item is
// set by 32 square root steps and two 18-step divisions in the shared unit. The first sample
// of a scan bypasses the unit, the second skips the turn products, a zero-length step the unit.
// Reset is synchronous; no clearing pass, the sine table is constant logic.
// A result waits in the output register; the next item is taken meanwhile,
// and its result stalls the sequencer until the register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scan_polar_turn_features_core #(
  parameter int MAX_SCAN_LENGTH  = 4096,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        range_mm,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] triple_start_angle,
  output logic signed [15:0] turn_cross,
  output logic signed [15:0] turn_dot,
  output logic               degenerate,
  output logic               last_of_scan
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int CW = $clog2(MAX_SCAN_LENGTH);
  localparam int LW = (CW + 1 > 13) ? CW + 1 : 13;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RDS  = 5'd1;
  localparam logic [4:0] S_MS   = 5'd2;
  localparam logic [4:0] S_PY   = 5'd3;
  localparam logic [4:0] S_PX   = 5'd4;
  localparam logic [4:0] S_DX   = 5'd5;
  localparam logic [4:0] S_DY   = 5'd6;
  localparam logic [4:0] S_SUM  = 5'd7;
  localparam logic [4:0] S_SQRT = 5'd8;
  localparam logic [4:0] S_DIVX = 5'd9;
  localparam logic [4:0] S_DIVY = 5'd10;
  localparam logic [4:0] S_M1   = 5'd11;
  localparam logic [4:0] S_M2   = 5'd12;
  localparam logic [4:0] S_M3   = 5'd13;
  localparam logic [4:0] S_M4   = 5'd14;
  localparam logic [4:0] S_M5   = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  function automatic logic signed [15:0] sine_entry(input int n);
    longint unsigned q4, quad, t, tt, x, x2, term, pos, neg, val, tp;
    int k;
    q4   = 64'(4 * n);
    quad = q4 / SINE_TABLE_DEPTH;
    t    = ((q4 % SINE_TABLE_DEPTH) << 30) / SINE_TABLE_DEPTH;
    tt   = quad[0] ? ONE_Q30 - t : t;
    x    = (tt * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = 0;
    for (k = 1; k <= 6; k++) begin
      tp = (term * x2) >> 30;
      case (k)
        1:       term = tp / 64'd6;
        2:       term = tp / 64'd20;
        3:       term = tp / 64'd42;
        4:       term = tp / 64'd72;
        5:       term = tp / 64'd110;
        default: term = tp / 64'd156;
      endcase
      if (k % 2 == 1) neg += term;
      else pos += term;
    end
    if (neg >= pos) val = 0;
    else val = (pos - neg + 64'd16384) >> 15;
    if (val > 64'd32767) val = 64'd32767;
    return quad[1] ? -$signed(val[15:0]) : $signed(val[15:0]);
  endfunction

  function automatic logic signed [15:0] rnd_sat(input logic signed [37:0] v);
    logic signed [37:0] t;
    t = (v + 38'sd16384) >>> 15;
    if (t > 38'sd32767) return 16'sh7FFF;
    if (t < -38'sd32768) return 16'sh8000;
    return t[15:0];
  endfunction

  function automatic logic signed [15:0] unit_of(input logic neg, input logic [17:0] q);
    logic signed [18:0] v;
    v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (v > 19'sd32767) return 16'sh7FFF;
    if (v < -19'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [IW-1:0] rom_idx(input logic [15:0] a);
    logic [31:0] p;
    p = {16'b0, a} * 32'(SINE_TABLE_DEPTH);
    return p[16 +: IW];
  endfunction

  logic signed [15:0] sine_tab [SINE_TABLE_DEPTH];
  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_sine
    assign sine_tab[gi] = sine_entry(gi);
  end

  logic [4:0]         state;
  logic [15:0]        cfg_start, cfg_step;
  logic [12:0]        cfg_len;
  logic [CW-1:0]      count;
  logic [15:0]        beam_angle;
  logic [15:0]        ang_r;
  logic [15:0]        range_r;
  logic signed [15:0] rom_q;
  logic [IW-1:0]      rom_addr;
  logic signed [16:0] px_r, py_r, ppx, ppy;
  logic signed [17:0] dx_r, dy_r;
  logic signed [15:0] ux, uy, pux, puy;
  logic signed [37:0] prod, acc, cross_r, dot_r;
  logic signed [18:0] ma, mb;
  logic [31:0]        len_r;
  logic [LW-1:0]      len_eff, sl;
  logic               last;
  logic               in_fire, out_free, out_load;
  logic signed [37:0] pt_t;
  logic [36:0]        sum_s;
  logic [31:0]        root_now;
  logic signed [17:0] d_sel;
  logic [17:0]        d_abs;
  sptf_pkg::iter_req_t req;
  sptf_pkg::iter_rsp_t rsp;

  sptf_iter u_iter (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == S_OUT) && (count >= CW'(2)) && out_free;

  assign sl      = LW'(cfg_len);
  assign len_eff = (sl < LW'(3)) ? LW'(3) :
                   (sl > LW'(MAX_SCAN_LENGTH)) ? LW'(MAX_SCAN_LENGTH) : sl;
  assign last    = (LW'(count) + LW'(1)) >= len_eff;

  assign rom_addr = (state == S_RDS) ? rom_idx(ang_r) : rom_idx(ang_r + 16'd16384);
  assign pt_t     = prod + 38'sd16384;
  assign sum_s    = 37'(acc + prod);

  always_comb begin
    case (state)
      S_MS, S_PY: begin
        ma = {3'b000, range_r};
        mb = 19'(rom_q);
      end
      S_DX: begin
        ma = 19'(px_r - ppx);
        mb = 19'(px_r - ppx);
      end
      S_DY: begin
        ma = 19'(dy_r);
        mb = 19'(dy_r);
      end
      S_M1: begin
        ma = 19'(pux);
        mb = 19'(uy);
      end
      S_M2: begin
        ma = 19'(ux);
        mb = 19'(puy);
      end
      S_M3: begin
        ma = 19'(pux);
        mb = 19'(ux);
      end
      S_M4: begin
        ma = 19'(puy);
        mb = 19'(uy);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign root_now = (state == S_SQRT) ? rsp.root : len_r;
  assign d_sel    = (state == S_SQRT) ? dx_r : dy_r;
  assign d_abs    = d_sel[17] ? 18'(-d_sel) : 18'(d_sel);

  always_comb begin
    req.start    = ((state == S_SUM) && (sum_s != '0)) ||
                   (((state == S_SQRT) || (state == S_DIVX)) && rsp.done);
    req.op       = (state == S_SUM) ? sptf_pkg::OP_SQRT : sptf_pkg::OP_DIV;
    req.radicand = {sum_s[35:0], 28'b0};
    req.num      = (49'(d_abs) << 30) + 49'(root_now);
    req.den      = {root_now, 1'b0};
  end

  always_ff @(posedge clk) begin
    prod  <= ma * mb;
    rom_q <= sine_tab[rom_addr];
    if (rst) begin
      state      <= S_IDLE;
      cfg_start  <= 16'hC000;
      cfg_step   <= 16'd16;
      cfg_len    <= 13'd720;
      count      <= '0;
      beam_angle <= 16'hC000;
      ppx        <= '0;
      ppy        <= '0;
      pux        <= '0;
      puy        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sptf_pkg::CFG_ANGLE_START: cfg_start <= cfg_data;
          sptf_pkg::CFG_ANGLE_STEP:  cfg_step  <= cfg_data;
          sptf_pkg::CFG_SCAN_LENGTH: cfg_len   <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            range_r <= range_mm;
            ang_r   <= (count == '0) ? cfg_start : beam_angle;
            state   <= S_RDS;
          end
        end
        S_RDS: state <= S_MS;
        S_MS:  state <= S_PY;
        S_PY: begin
          py_r  <= pt_t[31:15];
          state <= S_PX;
        end
        S_PX: begin
          px_r <= pt_t[31:15];
          ux   <= '0;
          uy   <= '0;
          if (count == '0) state <= S_OUT;
          else state <= S_DX;
        end
        S_DX: begin
          dx_r  <= 18'(px_r - ppx);
          dy_r  <= 18'(py_r - ppy);
          state <= S_DY;
        end
        S_DY: begin
          acc   <= prod;
          state <= S_SUM;
        end
        S_SUM: begin
          if (sum_s != '0) state <= S_SQRT;
          else if (count >= CW'(2)) state <= S_M1;
          else state <= S_OUT;
        end
        S_SQRT: begin
          if (rsp.done) begin
            len_r <= rsp.root;
            state <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (rsp.done) begin
            ux    <= unit_of(dx_r[17], rsp.quot);
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (rsp.done) begin
            uy <= unit_of(dy_r[17], rsp.quot);
            if (count >= CW'(2)) state <= S_M1;
            else state <= S_OUT;
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin
          acc   <= prod;
          state <= S_M3;
        end
        S_M3: begin
          cross_r <= acc - prod;
          state   <= S_M4;
        end
        S_M4: begin
          acc   <= prod;
          state <= S_M5;
        end
        S_M5: begin
          dot_r <= acc + prod;
          state <= S_OUT;
        end
        S_OUT: begin
          if ((count < CW'(2)) || out_free) begin
            if (count >= CW'(2)) begin
              triple_start_angle <= ang_r - {cfg_step[14:0], 1'b0};
              turn_cross         <= rnd_sat(cross_r);
              turn_dot           <= rnd_sat(dot_r);
              degenerate         <= ((ux == '0) && (uy == '0)) ||
                                    ((pux == '0) && (puy == '0));
              last_of_scan       <= last;
            end
            ppx        <= px_r;
            ppy        <= py_r;
            pux        <= ux;
            puy        <= uy;
            beam_angle <= ang_r + cfg_step;
            count      <= last ? '0 : CW'(count + CW'(1));
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SPTF_ASSERT_NXT(a_busy_after_accept, clk, rst, in_fire, !in_ready)
  `SPTF_ASSERT_IMP(a_done_when_waited, clk, rst, rsp.done,
    (state == S_SQRT) || (state == S_DIVX) || (state == S_DIVY))
  `SPTF_ASSERT_IMP(a_degenerate_zero, clk, rst, out_valid && degenerate,
    (turn_cross == 16'sd0) && (turn_dot == 16'sd0))

endmodule

// ===== rtl/sptf_iter.sv =====
// Shared shift-subtract unit: integer square root and unsigned division
`timescale 1ns / 1ps
module sptf_iter (
  input  logic                clk,
  input  logic                rst,
  input  sptf_pkg::iter_req_t req,
  output sptf_pkg::iter_rsp_t rsp
);

  logic        busy;
  logic        op;
  logic [4:0]  cnt;
  logic [63:0] rad;
  logic [33:0] rem;
  logic [31:0] root;
  logic [17:0] nlow;
  logic [17:0] quot;
  logic [32:0] den;
  logic        done;

  logic [35:0] sq_r2;
  logic [35:0] sq_trial;
  logic [33:0] dv_r2;

  assign sq_r2    = {rem, rad[63:62]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign dv_r2    = {rem[32:0], nlow[17]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        den  <= req.den;
        rad  <= req.radicand;
        root <= '0;
        quot <= '0;
        if (req.op == sptf_pkg::OP_DIV) begin
          cnt  <= 5'd17;
          rem  <= {3'b000, req.num[48:18]};
          nlow <= req.num[17:0];
        end else begin
          cnt <= 5'd31;
          rem <= '0;
        end
      end else if (busy) begin
        if (op == sptf_pkg::OP_DIV) begin
          nlow <= {nlow[16:0], 1'b0};
          if (dv_r2 >= {1'b0, den}) begin
            rem  <= dv_r2 - {1'b0, den};
            quot <= {quot[16:0], 1'b1};
          end else begin
            rem  <= dv_r2;
            quot <= {quot[16:0], 1'b0};
          end
        end else begin
          rad <= {rad[61:0], 2'b00};
          if (sq_r2 >= sq_trial) begin
            rem  <= 34'(sq_r2 - sq_trial);
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= sq_r2[33:0];
            root <= {root[30:0], 1'b0};
          end
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;
  assign rsp.quot = quot;

endmodule
